// ----- hdl/srrw_pkg.sv -----
// Shared types, constants and defaults for the selective-repeat receive window.
package srrw_pkg;

   localparam int SEQ_SPACE_DEF    = 8;
   localparam int WINDOW_DEF       = 4;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int SEQ_W        = 3;
   localparam int DATA_W       = 64;
   localparam int ACK_W        = 3;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 72;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMIT,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

   typedef struct packed {
      logic load;
      logic kind;
      logic last;
   } rsp_load_type;

endpackage

// ----- hdl/srrw_slot_mem.sv -----
// Payload slot memory: one write port, one registered read port.
module srrw_slot_mem #(
   parameter int SEQ_SPACE    = srrw_pkg::SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                           clock,
   input  srrw_pkg::mem_ctrl_type         mem_ctrl,
   input  logic [$clog2(SEQ_SPACE)-1:0]   wr_addr,
   input  logic [PAYLOAD_BITS-1:0]        wr_data,
   input  logic [$clog2(SEQ_SPACE)-1:0]   rd_addr,
   output logic [PAYLOAD_BITS-1:0]        rd_data
);
   import srrw_pkg::*;

   logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/srrw_ctrl.sv -----
// Window control: base pointer, slot valid bits and the delivery sequencer.
module srrw_ctrl #(
   parameter int SEQ_SPACE = srrw_pkg::SEQ_SPACE_DEF,
   parameter int WINDOW    = srrw_pkg::WINDOW_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srrw_pkg::SEQ_W-1:0]     seq_num,
   input  logic                           checksum_ok,
   input  logic                           out_free,
   output srrw_pkg::mem_ctrl_type         mem_ctrl,
   output logic [$clog2(SEQ_SPACE)-1:0]   wr_addr,
   output logic [$clog2(SEQ_SPACE)-1:0]   rd_addr,
   output srrw_pkg::rsp_load_type         rsp_load,
   output logic [srrw_pkg::ACK_W-1:0]     ack_num
);
   import srrw_pkg::*;

   localparam int SW = $clog2(SEQ_SPACE);
   localparam int RW = ((SW > SEQ_W) ? SW : SEQ_W) + 1;
   localparam int CW = $clog2(WINDOW + 1);

   state_type               state_ff, state_in;
   logic [SW-1:0]           base_ff, base_in;
   logic [SEQ_SPACE-1:0]    valid_ff, valid_in;
   logic [CW-1:0]           count_ff, count_in;

   logic [RW-1:0]           seq_red;
   logic [SW-1:0]           seq;
   logic [RW-1:0]           offset;
   logic                    in_win;
   logic [SW-1:0]           base_next;
   logic [RW-1:0]           base_wide;

   // seq_num < 8 and SEQ_SPACE >= 2, so three conditional subtracts reduce it
   always_comb begin
      seq_red = RW'(seq_num);
      for (int i = 0; i < 3; i++) begin
         if (seq_red >= RW'(SEQ_SPACE)) begin
            seq_red = seq_red - RW'(SEQ_SPACE);
         end
      end
      seq = seq_red[SW-1:0];
   end

   always_comb begin
      if (seq >= base_ff) begin
         offset = RW'(seq) - RW'(base_ff);
      end else begin
         offset = RW'(seq) + RW'(SEQ_SPACE) - RW'(base_ff);
      end
      in_win = (WINDOW >= SEQ_SPACE) || (offset < RW'(WINDOW));
   end

   assign base_next = (base_ff == SW'(SEQ_SPACE - 1)) ? '0 : base_ff + 1'b1;
   assign base_wide = RW'(base_ff);
   assign ack_num   = base_wide[ACK_W-1:0];
   assign wr_addr   = seq;
   assign rd_addr   = base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_ff  <= '0;
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      valid_in   = valid_ff;
      count_in   = count_ff;
      mem_ctrl   = '0;
      rsp_load   = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && checksum_ok) begin
               if (in_win && !valid_ff[seq]) begin
                  mem_ctrl.wr_en = 1'b1;
                  valid_in[seq]  = 1'b1;
               end
               if (seq == base_ff) begin
                  count_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end
         ST_DRAIN: begin
            if ((count_ff < CW'(WINDOW)) && valid_ff[base_ff]) begin
               mem_ctrl.rd_en    = 1'b1;
               valid_in[base_ff] = 1'b0;
               base_in           = base_next;
               count_in          = count_ff + 1'b1;
               state_in          = ST_EMIT;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load.load = 1'b1;
               rsp_load.kind = KIND_DATA;
               rsp_load.last = 1'b0;
               state_in      = ST_DRAIN;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_load.load = 1'b1;
               rsp_load.kind = KIND_ACK;
               rsp_load.last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WINDOW))
      else $error("delivery run exceeded window");

   a_valid_bound: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= WINDOW)
      else $error("more buffered slots than window size");

   a_base_moves_in_drain: assert property (@(posedge clock) disable iff (reset)
      (base_ff != $past(base_ff)) |-> ($past(state_ff) == ST_DRAIN))
      else $error("window base moved outside delivery run");

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && $past(state_ff) != ST_EMIT) |->
         ($past(state_ff) == ST_DRAIN && $past(mem_ctrl.rd_en)))
      else $error("delivery without slot read");
`endif

endmodule

// ----- hdl/selective_repeat_receive_window.sv -----
// Selective-repeat ARQ receive window: top level with output word register.
// A packet off the window base goes straight to the ack state, then loads the ack word.
// At the base: per delivered word a slot read, then a load; then the run check, then the ack.
// A new packet is taken only in idle, after the last ack; a corrupt one gets no word.
// The sequencer reads one slot and loads it before the next read; output stalls hold it.
// Reset clears the window base, slot valid bits and output valid; the payload RAM is not cleared.
module selective_repeat_receive_window #(
   parameter int SEQ_SPACE    = srrw_pkg::SEQ_SPACE_DEF,
   parameter int WINDOW       = srrw_pkg::WINDOW_DEF,
   parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srrw_pkg::REQ_TDATA_W-1:0]    req_tdata,  // seq_num[2:0], payload[66:3]
   input  logic                                req_tuser,  // checksum_ok[0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srrw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // data_out[63:0], ack_num[66:64]
   output logic                                rsp_tuser,  // kind[0]
   output logic                                rsp_tlast
);
   import srrw_pkg::*;

   localparam int SW = $clog2(SEQ_SPACE);

   mem_ctrl_type            mem_ctrl;
   rsp_load_type            rsp_load;
   logic [SW-1:0]           wr_addr;
   logic [SW-1:0]           rd_addr;
   logic [PAYLOAD_BITS-1:0] rd_data;
   logic [ACK_W-1:0]        ack_num;
   logic                    out_free;

   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic                    rsp_last_ff;
   logic [PAYLOAD_BITS-1:0] rsp_data_ff;
   logic [ACK_W-1:0]        rsp_ack_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   srrw_ctrl #(
      .SEQ_SPACE (SEQ_SPACE),
      .WINDOW    (WINDOW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .seq_num     (req_tdata[SEQ_W-1:0]),
      .checksum_ok (req_tuser),
      .out_free    (out_free),
      .mem_ctrl    (mem_ctrl),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .rsp_load    (rsp_load),
      .ack_num     (ack_num)
   );

   srrw_slot_mem #(
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_mem (
      .clock    (clock),
      .mem_ctrl (mem_ctrl),
      .wr_addr  (wr_addr),
      .wr_data  (req_tdata[SEQ_W +: PAYLOAD_BITS]),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rsp_kind_ff <= rsp_load.kind;
         rsp_last_ff <= rsp_load.last;
         rsp_data_ff <= (rsp_load.kind == KIND_ACK) ? '0 : rd_data;
         rsp_ack_ff  <= (rsp_load.kind == KIND_ACK) ? ack_num : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_ack_ff, DATA_W'(rsp_data_ff)});

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the selective-repeat receive window.
`timescale 1ns / 1ps

module tb_top;
   import srrw_pkg::*;

   localparam int WINDOW     = WINDOW_DEF;
   localparam int IDLE_LIMIT = 4000;
   localparam int RAND_ITEMS = 92;

   typedef struct packed {
      logic              kind;
      logic [DATA_W-1:0] data;
      logic [ACK_W-1:0]  ack;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic              ok;
      logic [DATA_W-1:0] payload;
      logic              typed;    // expected words given in the row
      logic [1:0]        t_words;  // 0: none, 1: ack only, 2: this payload then ack
      logic [ACK_W-1:0]  t_ack;
   } pkt_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // seq_num[2:0], payload[66:3]
   logic                   req_tuser = 1'b0; // checksum_ok[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // data_out[63:0], ack_num[66:64]
   logic                   rsp_tuser;        // kind[0]
   logic                   rsp_tlast;

   // receiver-side model state
   logic [SEQ_W-1:0]  rx_base;
   logic              slot_full [8];
   logic [DATA_W-1:0] slot_word [8];

   rsp_word_type awaited_words [$];
   rsp_word_type step_words [$];
   pkt_row_type  dir_rows [$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   int        burst_left = 0;
   logic [9:0] stall_cyc = '0;

   selective_repeat_receive_window uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
   endtask

   function automatic rsp_word_type make_word(input logic kind, input logic [DATA_W-1:0] data,
                                              input logic [ACK_W-1:0] ack, input logic last);
      rsp_word_type w;
      w.kind = kind;
      w.data = data;
      w.ack  = ack;
      w.last = last;
      return w;
   endfunction

   // Advance the window for one accepted packet; fills step_words.
   function automatic void window_accept(input logic [SEQ_W-1:0] seq, input logic ok,
                                         input logic [DATA_W-1:0] payload);
      logic [SEQ_W-1:0] offset;
      int               count;
      step_words.delete();
      if (!ok) return;
      offset = seq - rx_base;
      if (offset < WINDOW) begin
         if (!slot_full[seq]) begin
            slot_word[seq] = payload;
            slot_full[seq] = 1'b1;
         end
         if (seq == rx_base) begin
            count = 0;
            while (count < WINDOW && slot_full[rx_base]) begin
               step_words.push_back(make_word(KIND_DATA, slot_word[rx_base], '0, 1'b0));
               slot_full[rx_base] = 1'b0;
               rx_base = rx_base + 1'b1;
               count++;
            end
         end
      end
      step_words.push_back(make_word(KIND_ACK, '0, rx_base, 1'b1));
   endfunction

   task automatic add_row(input logic [SEQ_W-1:0] seq, input logic ok,
                          input logic [DATA_W-1:0] payload, input logic typed,
                          input logic [1:0] t_words, input logic [ACK_W-1:0] t_ack);
      pkt_row_type r;
      r.seq     = seq;
      r.ok      = ok;
      r.payload = payload;
      r.typed   = typed;
      r.t_words = t_words;
      r.t_ack   = t_ack;
      dir_rows.push_back(r);
   endtask

   task automatic send_packet(input pkt_row_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, r.payload, r.seq};
      req_tuser  <= r.ok;
      do @(posedge clock); while (!req_tready);
      window_accept(r.seq, r.ok, r.payload);
      if (r.typed) begin
         if (r.t_words == 2'd2)
            awaited_words.push_back(make_word(KIND_DATA, r.payload, '0, 1'b0));
         if (r.t_words != 2'd0)
            awaited_words.push_back(make_word(KIND_ACK, '0, r.t_ack, 1'b1));
      end else begin
         foreach (step_words[i]) awaited_words.push_back(step_words[i]);
      end
   endtask

   // result channel: stall pattern and checker
   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1'b1;
      case (stall_cyc[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= stall_cyc[2:0] != 3'd0;
         default: rsp_tready <= stall_cyc[1];
      endcase
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[63:0], '0);
         end else begin
            want = awaited_words.pop_front();
            if (rsp_tuser != want.kind)
               report_mismatch("kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[63:0] != want.data)
               report_mismatch("data_out", rsp_tdata[63:0], want.data);
            if (rsp_tdata[66:64] != want.ack)
               report_mismatch("ack_num", 64'(rsp_tdata[66:64]), 64'(want.ack));
            if (rsp_tlast != want.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      pkt_row_type r;
      int          pick;
      rx_base = '0;
      foreach (slot_full[i]) begin
         slot_full[i] = 1'b0;
         slot_word[i] = '0;
      end

      // seq, ok, payload, typed, words, ack
      add_row(3'd0, 1'b0, 64'h0123_4567_89ab_cdef, 1'b1, 2'd0, 3'd0); // corrupt at base
      add_row(3'd4, 1'b1, 64'h0,                   1'b1, 2'd1, 3'd0); // beyond window
      add_row(3'd7, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, 2'd1, 3'd0); // behind window
      add_row(3'd0, 1'b1, 64'hffff_ffff_ffff_ffff, 1'b1, 2'd2, 3'd1); // in order
      add_row(3'd2, 1'b1, 64'h0,                   1'b0, 2'd0, 3'd0);
      add_row(3'd3, 1'b1, 64'h5555_5555_5555_5555, 1'b0, 2'd0, 3'd0);
      add_row(3'd3, 1'b1, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 2'd0, 3'd0); // duplicate
      add_row(3'd4, 1'b1, 64'h8000_0000_0000_0001, 1'b0, 2'd0, 3'd0); // window edge
      add_row(3'd1, 1'b1, 64'h7fff_ffff_ffff_fffe, 1'b0, 2'd0, 3'd0); // full run
      add_row(3'd5, 1'b0, 64'hdead_beef_dead_beef, 1'b1, 2'd0, 3'd0); // corrupt
      add_row(3'd0, 1'b1, 64'h0000_0000_ffff_ffff, 1'b0, 2'd0, 3'd0); // wraps
      add_row(3'd7, 1'b1, 64'hffff_ffff_0000_0000, 1'b0, 2'd0, 3'd0);
      add_row(3'd6, 1'b1, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0, 2'd0, 3'd0);
      add_row(3'd6, 1'b1, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0, 2'd0, 3'd0); // duplicate
      add_row(3'd5, 1'b1, 64'h3333_cccc_3333_cccc, 1'b0, 2'd0, 3'd0); // run across wrap
      add_row(3'd1, 1'b0, 64'h1,                   1'b1, 2'd0, 3'd0); // corrupt at base
      add_row(3'd1, 1'b1, 64'h1,                   1'b0, 2'd0, 3'd0);
      add_row(3'd1, 1'b1, 64'h2,                   1'b0, 2'd0, 3'd0); // old packet

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_packet(dir_rows[i]);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         pick    = $urandom_range(0, 99);
         r.typed = 1'b0;
         r.t_words = '0;
         r.t_ack = '0;
         r.ok    = 1'b1;
         if (pick < 70)
            r.seq = rx_base + 3'($urandom_range(0, WINDOW - 1));
         else
            r.seq = 3'($urandom_range(0, 7));
         if (pick >= 88) r.ok = 1'b0;
         case ($urandom_range(0, 19))
            0: r.payload = '0;
            1: r.payload = '1;
            default: r.payload = {$urandom, $urandom};
         endcase
         send_packet(r);
      end
      req_tvalid <= 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
